// ===== design/rbst_pkg.sv =====
// Shared types for the ray versus box slab test.
// No dependencies; used by rbst_axis_div and ray_box_slab_test.
package rbst_pkg;

   // Number of spatial axes handled by the block
   localparam int AXES = 3;

   // Per-axis flags that travel alongside the divider pipeline
   typedef struct packed {
      logic dzero;   // direction is zero on this axis
      logic pass;    // origin strictly inside the slab
      logic neg_lo;  // quotient sign for the lower bound
      logic neg_hi;  // quotient sign for the upper bound
      logic dneg;    // direction negative: swap entry and exit
   } axis_meta_type;

endpackage

// ===== design/rbst_if.sv =====
// Valid/ready channel interfaces for the ray versus box slab test.
// No dependencies.
interface rbst_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;
   logic signed [COORD_WIDTH-1:0] box_min_x;
   logic signed [COORD_WIDTH-1:0] box_min_y;
   logic signed [COORD_WIDTH-1:0] box_min_z;
   logic signed [COORD_WIDTH-1:0] box_max_x;
   logic signed [COORD_WIDTH-1:0] box_max_y;
   logic signed [COORD_WIDTH-1:0] box_max_z;

   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                   input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                 output ready);
endinterface

interface rbst_rsp_if ();
   logic valid;
   logic ready;
   logic hit;

   modport source (output valid, hit, input ready);
   modport sink (input valid, hit, output ready);
endinterface

// ===== design/rbst_axis_div.sv =====
// One axis of the slab test: two pipelined restoring dividers sharing a divisor,
// then saturation, sign and entry/exit swap. Depends on rbst_pkg.
module rbst_axis_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [COORD_WIDTH+FRAC_BITS-1:0]    num_lo,
   input  logic [COORD_WIDTH+FRAC_BITS-1:0]    num_hi,
   input  logic [COORD_WIDTH-1:0]              den,
   input  rbst_pkg::axis_meta_type             meta_in,
   output logic signed [COORD_WIDTH-1:0]       t_entry,
   output logic signed [COORD_WIDTH-1:0]       t_exit,
   output rbst_pkg::axis_meta_type             meta_out
);
   localparam int NW = COORD_WIDTH + FRAC_BITS;

   // Per stage: remainder, numerator shifting out while quotient shifts in
   logic [COORD_WIDTH-1:0]  rem_lo_ff [NW];
   logic [COORD_WIDTH-1:0]  rem_hi_ff [NW];
   logic [NW-1:0]           nq_lo_ff  [NW];
   logic [NW-1:0]           nq_hi_ff  [NW];
   logic [COORD_WIDTH-1:0]  den_ff    [NW];
   rbst_pkg::axis_meta_type meta_ff   [NW];

   logic [COORD_WIDTH-1:0]  rem_lo_in [NW];
   logic [COORD_WIDTH-1:0]  rem_hi_in [NW];
   logic [NW-1:0]           nq_lo_in  [NW];
   logic [NW-1:0]           nq_hi_in  [NW];

   logic signed [COORD_WIDTH-1:0] t_entry_ff, t_exit_ff, t_entry_in, t_exit_in;
   rbst_pkg::axis_meta_type       meta_out_ff;

   // One quotient bit per stage for both bounds
   always_comb begin
      logic [COORD_WIDTH-1:0] prev_rem_lo, prev_rem_hi, prev_den;
      logic [NW-1:0]          prev_nq_lo, prev_nq_hi;
      logic [COORD_WIDTH:0]   trial_lo, trial_hi, diff_lo, diff_hi;
      logic                   ge_lo, ge_hi;
      for (int k = 0; k < NW; k++) begin
         if (k == 0) begin
            prev_rem_lo = '0;
            prev_rem_hi = '0;
            prev_nq_lo  = num_lo;
            prev_nq_hi  = num_hi;
            prev_den    = den;
         end else begin
            prev_rem_lo = rem_lo_ff[k-1];
            prev_rem_hi = rem_hi_ff[k-1];
            prev_nq_lo  = nq_lo_ff[k-1];
            prev_nq_hi  = nq_hi_ff[k-1];
            prev_den    = den_ff[k-1];
         end
         trial_lo = {prev_rem_lo, prev_nq_lo[NW-1]};
         trial_hi = {prev_rem_hi, prev_nq_hi[NW-1]};
         diff_lo  = trial_lo - {1'b0, prev_den};
         diff_hi  = trial_hi - {1'b0, prev_den};
         ge_lo    = trial_lo >= {1'b0, prev_den};
         ge_hi    = trial_hi >= {1'b0, prev_den};
         rem_lo_in[k] = ge_lo ? diff_lo[COORD_WIDTH-1:0] : trial_lo[COORD_WIDTH-1:0];
         rem_hi_in[k] = ge_hi ? diff_hi[COORD_WIDTH-1:0] : trial_hi[COORD_WIDTH-1:0];
         nq_lo_in[k]  = {prev_nq_lo[NW-2:0], ge_lo};
         nq_hi_in[k]  = {prev_nq_hi[NW-2:0], ge_hi};
      end
   end

   // Saturate, apply sign, swap for a negative direction
   always_comb begin
      logic [NW-1:0]          lim_pos, lim_lo, lim_hi, qs_lo, qs_hi;
      logic [COORD_WIDTH-1:0] t_lo, t_hi;
      lim_pos = NW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
      lim_lo  = meta_ff[NW-1].neg_lo ? lim_pos + NW'(1) : lim_pos;
      lim_hi  = meta_ff[NW-1].neg_hi ? lim_pos + NW'(1) : lim_pos;
      qs_lo   = (nq_lo_ff[NW-1] > lim_lo) ? lim_lo : nq_lo_ff[NW-1];
      qs_hi   = (nq_hi_ff[NW-1] > lim_hi) ? lim_hi : nq_hi_ff[NW-1];
      t_lo    = meta_ff[NW-1].neg_lo ? -qs_lo[COORD_WIDTH-1:0] : qs_lo[COORD_WIDTH-1:0];
      t_hi    = meta_ff[NW-1].neg_hi ? -qs_hi[COORD_WIDTH-1:0] : qs_hi[COORD_WIDTH-1:0];
      t_entry_in = meta_ff[NW-1].dneg ? t_hi : t_lo;
      t_exit_in  = meta_ff[NW-1].dneg ? t_lo : t_hi;
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NW; k++) begin
            rem_lo_ff[k] <= rem_lo_in[k];
            rem_hi_ff[k] <= rem_hi_in[k];
            nq_lo_ff[k]  <= nq_lo_in[k];
            nq_hi_ff[k]  <= nq_hi_in[k];
            den_ff[k]    <= (k == 0) ? den : den_ff[(k == 0) ? 0 : k-1];
            meta_ff[k]   <= (k == 0) ? meta_in : meta_ff[(k == 0) ? 0 : k-1];
         end
         t_entry_ff  <= t_entry_in;
         t_exit_ff   <= t_exit_in;
         meta_out_ff <= meta_ff[NW-1];
      end
   end

   assign t_entry  = t_entry_ff;
   assign t_exit   = t_exit_ff;
   assign meta_out = meta_out_ff;

endmodule

// ===== design/ray_box_slab_test.sv =====
// Ray versus axis-aligned box slab test, top level. Depends on rbst_pkg,
// rbst_if and rbst_axis_div.
// Structure: an input register, one bit-stage per quotient bit, then output, reduction and decision registers.
// Throughput: one request per cycle; the whole pipeline holds while a result waits
// and the output is not taken.
// Reset: synchronous, clears the valid bits only; no results are pending after reset.
module ray_box_slab_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input logic        clock,
   input logic        reset,
   rbst_req_if.sink   req_chan,
   rbst_rsp_if.source rsp_chan
);
   localparam int NW     = COORD_WIDTH + FRAC_BITS;
   localparam int STAGES = NW + 4;
   localparam int AX     = rbst_pkg::AXES;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic              advance;

   logic signed [COORD_WIDTH-1:0] org [AX];
   logic signed [COORD_WIDTH-1:0] dir [AX];
   logic signed [COORD_WIDTH-1:0] bmin [AX];
   logic signed [COORD_WIDTH-1:0] bmax [AX];

   logic [NW-1:0]           num_lo_ff [AX], num_lo_in [AX];
   logic [NW-1:0]           num_hi_ff [AX], num_hi_in [AX];
   logic [COORD_WIDTH-1:0]  den_ff    [AX], den_in    [AX];
   rbst_pkg::axis_meta_type meta_ff   [AX], meta_in   [AX];

   logic signed [COORD_WIDTH-1:0] t_entry [AX];
   logic signed [COORD_WIDTH-1:0] t_exit  [AX];
   rbst_pkg::axis_meta_type       meta_q  [AX];

   logic signed [COORD_WIDTH-1:0] entry_ff, entry_in, exit_ff, exit_in;
   logic                          allpass_ff, allpass_in, finite_ff, finite_in;
   logic                          hit_ff, hit_in;

   assign org[0]  = req_chan.origin_x;
   assign org[1]  = req_chan.origin_y;
   assign org[2]  = req_chan.origin_z;
   assign dir[0]  = req_chan.dir_x;
   assign dir[1]  = req_chan.dir_y;
   assign dir[2]  = req_chan.dir_z;
   assign bmin[0] = req_chan.box_min_x;
   assign bmin[1] = req_chan.box_min_y;
   assign bmin[2] = req_chan.box_min_z;
   assign bmax[0] = req_chan.box_max_x;
   assign bmax[1] = req_chan.box_max_y;
   assign bmax[2] = req_chan.box_max_z;

   // Hold everything while the output waits
   assign advance        = !valid_ff[STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign valid_in       = {valid_ff[STAGES-2:0], req_chan.valid};

   // Form numerator magnitudes, divisor magnitude and axis flags
   always_comb begin
      logic signed [COORD_WIDTH:0] d_lo, d_hi;
      logic [COORD_WIDTH:0]        m_lo, m_hi;
      logic [COORD_WIDTH-1:0]      dm;
      logic                        dneg;
      for (int a = 0; a < AX; a++) begin
         d_lo = {bmin[a][COORD_WIDTH-1], bmin[a]} - {org[a][COORD_WIDTH-1], org[a]};
         d_hi = {bmax[a][COORD_WIDTH-1], bmax[a]} - {org[a][COORD_WIDTH-1], org[a]};
         m_lo = d_lo[COORD_WIDTH] ? -d_lo : d_lo;
         m_hi = d_hi[COORD_WIDTH] ? -d_hi : d_hi;
         dneg = dir[a][COORD_WIDTH-1];
         dm   = dneg ? -dir[a] : dir[a];
         num_lo_in[a] = NW'(m_lo[COORD_WIDTH-1:0]) << FRAC_BITS;
         num_hi_in[a] = NW'(m_hi[COORD_WIDTH-1:0]) << FRAC_BITS;
         den_in[a]    = dm;
         meta_in[a].dzero  = (dir[a] == '0);
         meta_in[a].pass   = (bmin[a] < org[a]) && (org[a] < bmax[a]);
         meta_in[a].neg_lo = d_lo[COORD_WIDTH] ^ dneg;
         meta_in[a].neg_hi = d_hi[COORD_WIDTH] ^ dneg;
         meta_in[a].dneg   = dneg;
      end
   end

   // Per-axis divider pipelines
   for (genvar a = 0; a < AX; a++) begin : g_axis
      rbst_axis_div #(
         .COORD_WIDTH(COORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .en      (advance),
         .num_lo  (num_lo_ff[a]),
         .num_hi  (num_hi_ff[a]),
         .den     (den_ff[a]),
         .meta_in (meta_ff[a]),
         .t_entry (t_entry[a]),
         .t_exit  (t_exit[a]),
         .meta_out(meta_q[a])
      );
   end

   // Reduce to latest entry and earliest exit over axes with a direction; axes with a zero direction must pass
   always_comb begin
      entry_in   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      exit_in    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      allpass_in = 1'b1;
      finite_in  = 1'b0;
      for (int a = 0; a < AX; a++) begin
         if (meta_q[a].dzero) begin
            allpass_in = allpass_in && meta_q[a].pass;
         end else begin
            finite_in = 1'b1;
            if (t_entry[a] > entry_in) entry_in = t_entry[a];
            if (t_exit[a] < exit_in) exit_in = t_exit[a];
         end
      end
   end

   // Final decision
   assign hit_in = allpass_ff && (!finite_ff || (entry_ff < exit_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < AX; a++) begin
            num_lo_ff[a] <= num_lo_in[a];
            num_hi_ff[a] <= num_hi_in[a];
            den_ff[a]    <= den_in[a];
            meta_ff[a]   <= meta_in[a];
         end
         entry_ff   <= entry_in;
         exit_ff    <= exit_in;
         allpass_ff <= allpass_in;
         finite_ff  <= finite_in;
         hit_ff     <= hit_in;
      end
   end

   assign rsp_chan.valid = valid_ff[STAGES-1];
   assign rsp_chan.hit   = hit_ff;

endmodule
